@@ src/ctpf_pkg.sv @@
// Shared types and constants for the CD-Text pack framer.
`timescale 1ns / 1ps

package ctpf_pkg;

    localparam int PAYLOAD_LEN = 12;

    localparam logic [4:0] IDX_CRC_HI = 5'd16;
    localparam logic [4:0] IDX_LAST   = 5'd17;
    localparam logic [4:0] IDX_BODY   = 5'd4;

    localparam logic [7:0]  SEQ_LIMIT      = 8'd253;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [7:0]  TYPE_TITLE     = 8'h80;
    localparam logic [7:0]  TYPE_PERFORMER = 8'h81;
    localparam logic [7:0]  TYPE_SIZE      = 8'h8F;
    localparam logic [3:0]  POS_MAX        = 4'd15;
    localparam logic [7:0]  SIZE_BLOCK_SEQ = 8'd3;
    localparam logic [1:0]  SIZE_PACK_LAST = 2'd2;

    localparam int CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_TEXT,
        CMD_END,
        CMD_FINISH
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHARACTER_CODE,
        REG_LANGUAGE_CODE
    } cfg_reg_t;

    typedef struct packed {
        logic set_kind;
        logic store_byte;
        logic clear_fill;
        logic clear_pos;
        logic mark_overflow;
        logic start_text;
        logic start_size;
        logic emit;
        logic emit_last;
        logic emit_error;
        logic text_done;
        logic clear_session;
    } ctl_t;

    typedef struct packed {
        logic overflowed;
        logic seq_full;
        logic fill_empty;
        logic fill_last;
        logic pack_done;
        logic size_done;
        logic out_free;
    } status_t;

endpackage

@@ src/ctpf_ctrl.sv @@
// Command sequencer for the CD-Text pack framer.
`timescale 1ns / 1ps

module ctpf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  ctpf_pkg::status_t  status,
    output ctpf_pkg::ctl_t     ctl
);
    import ctpf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEXT,
        ST_SIZE,
        ST_ERR
    } state_t;

    state_t state_reg;
    state_t state_next;
    cmd_t   cmd;

    assign cmd      = cmd_t'(command);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_BEGIN:
                        begin
                            ctl.set_kind   = 1'b1;
                            ctl.clear_fill = 1'b1;
                            ctl.clear_pos  = 1'b1;
                        end
                        CMD_TEXT:
                        begin
                            if (!status.overflowed)
                            begin
                                ctl.store_byte = 1'b1;
                                if (status.fill_last)
                                begin
                                    if (status.seq_full)
                                        ctl.mark_overflow = 1'b1;
                                    else
                                    begin
                                        ctl.start_text = 1'b1;
                                        state_next     = ST_TEXT;
                                    end
                                end
                            end
                        end
                        CMD_END:
                        begin
                            ctl.clear_pos = 1'b1;
                            if (!status.overflowed && !status.fill_empty)
                            begin
                                if (status.seq_full)
                                    ctl.mark_overflow = 1'b1;
                                else
                                begin
                                    ctl.start_text = 1'b1;
                                    state_next     = ST_TEXT;
                                end
                            end
                            else
                                ctl.clear_fill = 1'b1;
                        end
                        CMD_FINISH:
                        begin
                            if (status.overflowed)
                                state_next = ST_ERR;
                            else
                            begin
                                ctl.start_size = 1'b1;
                                state_next     = ST_SIZE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TEXT:
            begin
                if (status.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_last = status.pack_done;
                    if (status.pack_done)
                    begin
                        ctl.text_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_SIZE:
            begin
                if (status.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_last = status.size_done;
                    if (status.size_done)
                    begin
                        ctl.clear_session = 1'b1;
                        state_next        = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (status.out_free)
                begin
                    ctl.emit_error    = 1'b1;
                    ctl.clear_session = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ src/ctpf_datapath.sv @@
// Payload buffer, session counters, pack byte generator, CRC and output register.
`timescale 1ns / 1ps

module ctpf_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctpf_pkg::ctl_t     ctl,
    output ctpf_pkg::status_t  status,
    input  logic               pack_kind,
    input  logic [7:0]         text_byte,
    input  logic [6:0]         string_track,
    input  logic [6:0]         first_track,
    input  logic [6:0]         last_track,
    input  logic [7:0]         character_code,
    input  logic [7:0]         language_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               pack_end,
    output logic               last,
    output logic               error
);
    import ctpf_pkg::*;

    logic [7:0]  payload_reg [PAYLOAD_LEN];
    logic [3:0]  fill_reg;
    logic [7:0]  seq_reg;
    logic [3:0]  cpos_reg;
    logic [6:0]  track_reg;
    logic [3:0]  ppos_reg;
    logic        kind_reg;
    logic [7:0]  title_cnt_reg;
    logic [7:0]  perf_cnt_reg;
    logic        overflow_reg;

    logic [4:0]  idx_reg;
    logic [1:0]  pidx_reg;
    logic        size_mode_reg;
    logic [15:0] crc_reg;
    logic [6:0]  first_reg;
    logic [6:0]  last_trk_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        pack_end_reg;
    logic        last_reg;
    logic        error_reg;

    logic [4:0]  body_pos;
    logic [3:0]  slot;
    logic [7:0]  text_body;
    logic [7:0]  size_body;
    logic [7:0]  cur_byte;
    logic [3:0]  cpos_next;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign body_pos = idx_reg - IDX_BODY;
    assign slot     = body_pos[3:0];

    always_comb
    begin
        text_body = 8'h00;
        if (slot < fill_reg)
            text_body = payload_reg[slot];
    end

    always_comb
    begin
        size_body = 8'h00;
        case (pidx_reg)
            2'd0:
            begin
                case (slot)
                    4'd0:    size_body = character_code;
                    4'd1:    size_body = {1'b0, first_reg};
                    4'd2:    size_body = {1'b0, last_trk_reg};
                    4'd4:    size_body = title_cnt_reg;
                    4'd5:    size_body = perf_cnt_reg;
                    default: size_body = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (slot)
                    4'd7:    size_body = SIZE_BLOCK_SEQ;
                    4'd8:    size_body = seq_reg + 8'd2;
                    default: size_body = 8'h00;
                endcase
            end
            2'd2:
            begin
                case (slot)
                    4'd4:    size_body = language_code;
                    default: size_body = 8'h00;
                endcase
            end
            default:
            begin
                size_body = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            5'd0:
                cur_byte = size_mode_reg ? TYPE_SIZE : (kind_reg ? TYPE_PERFORMER : TYPE_TITLE);
            5'd1:
                cur_byte = size_mode_reg ? {6'b0, pidx_reg} : {1'b0, track_reg};
            5'd2:
                cur_byte = size_mode_reg ? (seq_reg + {6'b0, pidx_reg}) : seq_reg;
            5'd3:
                cur_byte = size_mode_reg ? 8'h00 : {4'b0, ppos_reg};
            IDX_CRC_HI:
                cur_byte = ~crc_reg[15:8];
            IDX_LAST:
                cur_byte = ~crc_reg[7:0];
            default:
                cur_byte = size_mode_reg ? size_body : text_body;
        endcase
    end

    always_comb
    begin
        if (text_byte == 8'h00)
            cpos_next = 4'd0;
        else if (cpos_reg < POS_MAX)
            cpos_next = cpos_reg + 4'd1;
        else
            cpos_next = cpos_reg;
    end

    assign status.overflowed = overflow_reg;
    assign status.seq_full   = (seq_reg >= SEQ_LIMIT);
    assign status.fill_empty = (fill_reg == 4'd0);
    assign status.fill_last  = (fill_reg == 4'(PAYLOAD_LEN - 1));
    assign status.pack_done  = (idx_reg == IDX_LAST);
    assign status.size_done  = (idx_reg == IDX_LAST) && (pidx_reg == SIZE_PACK_LAST);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (ctl.store_byte)
            payload_reg[fill_reg] <= text_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            seq_reg       <= '0;
            cpos_reg      <= '0;
            track_reg     <= '0;
            ppos_reg      <= '0;
            kind_reg      <= 1'b0;
            title_cnt_reg <= '0;
            perf_cnt_reg  <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.set_kind)
                kind_reg <= pack_kind;

            if (ctl.clear_session || ctl.mark_overflow || ctl.clear_fill || ctl.text_done)
                fill_reg <= '0;
            else if (ctl.store_byte)
                fill_reg <= fill_reg + 4'd1;

            if (ctl.clear_session || ctl.clear_pos)
                cpos_reg <= '0;
            else if (ctl.store_byte)
                cpos_reg <= cpos_next;

            if (ctl.clear_session)
            begin
                track_reg <= '0;
                ppos_reg  <= '0;
            end
            else if (ctl.store_byte && fill_reg == 4'd0)
            begin
                track_reg <= string_track;
                ppos_reg  <= cpos_reg;
            end

            if (ctl.clear_session)
            begin
                seq_reg       <= '0;
                title_cnt_reg <= '0;
                perf_cnt_reg  <= '0;
            end
            else if (ctl.text_done)
            begin
                seq_reg <= seq_reg + 8'd1;
                if (kind_reg)
                    perf_cnt_reg <= perf_cnt_reg + 8'd1;
                else
                    title_cnt_reg <= title_cnt_reg + 8'd1;
            end

            if (ctl.clear_session)
                overflow_reg <= 1'b0;
            else if (ctl.mark_overflow)
                overflow_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pidx_reg      <= '0;
            size_mode_reg <= 1'b0;
            crc_reg       <= '0;
        end
        else if (ctl.start_text || ctl.start_size)
        begin
            idx_reg       <= '0;
            pidx_reg      <= '0;
            size_mode_reg <= ctl.start_size;
            crc_reg       <= '0;
        end
        else if (ctl.emit)
        begin
            if (idx_reg == IDX_LAST)
            begin
                idx_reg  <= '0;
                pidx_reg <= pidx_reg + 2'd1;
                crc_reg  <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 5'd1;
                if (idx_reg < IDX_CRC_HI)
                    crc_reg <= crc_step(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start_size)
        begin
            first_reg    <= first_track;
            last_trk_reg <= last_track;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit || ctl.emit_error)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_byte_reg <= cur_byte;
            pack_end_reg <= (idx_reg == IDX_LAST);
            last_reg     <= ctl.emit_last;
            error_reg    <= 1'b0;
        end
        else if (ctl.emit_error)
        begin
            out_byte_reg <= 8'h00;
            pack_end_reg <= 1'b0;
            last_reg     <= 1'b1;
            error_reg    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign pack_end  = pack_end_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit || ctl.emit_error) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transaction");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.store_byte |-> (fill_reg < 4'(PAYLOAD_LEN)))
        else $error("payload write beyond buffer");

    a_pack_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && idx_reg == IDX_LAST) |=> (idx_reg == 5'd0 && crc_reg == 16'h0000))
        else $error("pack counter or CRC did not restart");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (overflow_reg && !ctl.clear_session) |=> overflow_reg)
        else $error("overflow dropped without finish");

endmodule

@@ src/cd_text_pack_framer_unit.sv @@
// Top level of the CD-Text pack framer: configuration registers and unit wiring.
`timescale 1ns / 1ps

// Begin commands and text bytes that do not complete a pack are taken in idle.
// A byte that fills the 12-byte payload, or an end command with a partial payload,
// starts one 18-byte pack; a finish emits three 18-byte size packs, or a single
// error result when it reports sequence overflow. in_ready stays low until the
// last result is loaded into the output register, which moves one pack byte per cycle
// unless out_ready is low with a byte pending; the CRC-16 is updated a byte at a time.
// character_code and language_code may be written only while the unit is idle.
module cd_text_pack_framer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         command,
    input  logic                               pack_kind,
    input  logic [7:0]                         text_byte,
    input  logic [6:0]                         string_track,
    input  logic [6:0]                         first_track,
    input  logic [6:0]                         last_track,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_byte,
    output logic                               pack_end,
    output logic                               last,
    output logic                               error,
    input  logic                               cfg_write,
    input  logic [ctpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_data
);
    import ctpf_pkg::*;

    logic [7:0] char_code_reg;
    logic [7:0] lang_code_reg;
    ctl_t       ctl;
    status_t    status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_code_reg <= 8'd1;
            lang_code_reg <= 8'd9;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CHARACTER_CODE: char_code_reg <= cfg_data;
                REG_LANGUAGE_CODE:  lang_code_reg <= cfg_data;
                default:            char_code_reg <= char_code_reg;
            endcase
        end
    end

    ctpf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .ctl      (ctl)
    );

    ctpf_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .pack_kind      (pack_kind),
        .text_byte      (text_byte),
        .string_track   (string_track),
        .first_track    (first_track),
        .last_track     (last_track),
        .character_code (char_code_reg),
        .language_code  (lang_code_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .pack_end       (pack_end),
        .last           (last),
        .error          (error)
    );

endmodule
